// File: rtl/core/bfa_pkg.sv
package bfa_pkg;

    localparam int NUM_ENTRIES = 128;
    localparam int WORD_W      = 32;
    localparam int NUM_WORDS   = NUM_ENTRIES / WORD_W;
    localparam int WADDR_W     = $clog2(NUM_WORDS);
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int NUM_W       = 8;
    localparam int OP_W        = 2;
    localparam int CFG_W       = 8;
    localparam int PDATA_W     = 32;
    localparam int PADDR_W     = 3;

    localparam logic [CFG_W-1:0] FIRST_RESET = CFG_W'(1);
    localparam logic [CFG_W-1:0] LAST_RESET  = CFG_W'(128);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_MARK    = 2'd2,
        OP_QUERY   = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        REG_FIRST = 1'b0,
        REG_LAST  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] first_searchable;
        logic [CFG_W-1:0] last_searchable;
    } t_cfg;

    typedef struct packed {
        logic               rd_en;
        logic [WADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0]  wdata;
    } t_ram_req;

    typedef struct packed {
        logic [NUM_W-1:0] free_total;
        logic             in_eval;
    } t_stat;

endpackage

// File: rtl/core/bfa_req_if.sv
interface bfa_req_if import bfa_pkg::*; ();
    logic             valid;
    logic             ready;
    t_op              op;
    logic [NUM_W-1:0] entry_number;

    modport source (output valid, output op, output entry_number, input ready);
    modport sink (input valid, input op, input entry_number, output ready);
endinterface

// File: rtl/core/bfa_rsp_if.sv
interface bfa_rsp_if import bfa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] result_number;
    logic             was_in_use;
    logic [NUM_W-1:0] free_left;
    logic             bad_number;

    modport source (
        output valid, output result_number, output was_in_use,
        output free_left, output bad_number, input ready
    );
    modport sink (
        input valid, input result_number, input was_in_use,
        input free_left, input bad_number, output ready
    );
endinterface

// File: rtl/core/bfa_map_ram.sv
module bfa_map_ram import bfa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ram_req          i_req,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0]    r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_row_valid;
    logic [WORD_W-1:0]    r_rdata;
    logic                 r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata  <= r_mem[i_req.rd_addr];
            r_rd_hit <= r_row_valid[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_req.wr_en) begin
            r_row_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rdata = r_rd_hit ? r_rdata : '0;

endmodule

// File: rtl/core/bfa_cfg_regs.sv
module bfa_cfg_regs import bfa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [CFG_W-1:0] r_first;
    logic [CFG_W-1:0] r_last;
    t_reg_idx         reg_idx;
    logic             wr_hit;

    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1]);
    assign wr_hit  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= FIRST_RESET;
            r_last  <= LAST_RESET;
        end else if (wr_hit) begin
            case (reg_idx)
                REG_FIRST: r_first <= pwdata[CFG_W-1:0];
                REG_LAST:  r_last  <= pwdata[CFG_W-1:0];
                default:   r_first <= r_first;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FIRST: prdata = PDATA_W'(r_first);
            REG_LAST:  prdata = PDATA_W'(r_last);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.first_searchable = r_first;
    assign o_cfg.last_searchable  = r_last;

endmodule

// File: rtl/core/bfa_ctrl.sv
module bfa_ctrl import bfa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    bfa_req_if.sink           i_req,
    bfa_rsp_if.source         o_rsp,
    output t_ram_req          o_ram,
    input  logic [WORD_W-1:0] i_ram_rdata,
    output t_stat             o_stat
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [WADDR_W-1:0] r_word, n_word;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [IDX_W-1:0]   r_lo0, n_lo0;
    logic [IDX_W-1:0]   r_hi0, n_hi0;
    logic [NUM_W-1:0]   r_free, n_free;
    logic [NUM_W-1:0]   r_res_num, n_res_num;
    logic               r_res_was, n_res_was;
    logic               r_res_bad, n_res_bad;
    logic               r_out_valid, n_out_valid;
    logic [NUM_W-1:0]   r_out_num;
    logic               r_out_was;
    logic [NUM_W-1:0]   r_out_free;
    logic               r_out_bad;

    logic [NUM_W-1:0]   lo8, hi8, lo_m1, hi_m1, num_m1;
    logic [IDX_W-1:0]   idx;
    logic               bad_in;
    logic               slot_free;
    logic               load_out;
    logic [WORD_W-1:0]  cand;
    logic               found;
    logic [BIT_W-1:0]   found_pos;
    logic [IDX_W-1:0]   found_idx;
    logic               was;

    assign lo8    = (i_cfg.first_searchable == '0) ? NUM_W'(1) : i_cfg.first_searchable;
    assign hi8    = (i_cfg.last_searchable > NUM_W'(NUM_ENTRIES))
                  ? NUM_W'(NUM_ENTRIES) : i_cfg.last_searchable;
    assign lo_m1  = lo8 - NUM_W'(1);
    assign hi_m1  = hi8 - NUM_W'(1);
    assign num_m1 = i_req.entry_number - NUM_W'(1);
    assign idx    = num_m1[IDX_W-1:0];
    assign bad_in = (i_req.entry_number == '0)
                 || (i_req.entry_number > NUM_W'(NUM_ENTRIES));

    assign slot_free = !r_out_valid || o_rsp.ready;
    assign load_out  = (r_state == S_DONE) && slot_free;

    always_comb begin
        cand      = '0;
        found_pos = '0;
        for (int p = 0; p < WORD_W; p++) begin
            cand[p] = !i_ram_rdata[p]
                   && ({r_word, BIT_W'(p)} >= r_lo0)
                   && ({r_word, BIT_W'(p)} <= r_hi0);
        end
        for (int p = WORD_W - 1; p >= 0; p--) begin
            if (cand[p]) begin
                found_pos = BIT_W'(p);
            end
        end
    end

    assign found     = |cand;
    assign found_idx = {r_word, found_pos};
    assign was       = i_ram_rdata[r_bit];

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_num     = r_num;
        n_word    = r_word;
        n_bit     = r_bit;
        n_lo0     = r_lo0;
        n_hi0     = r_hi0;
        n_free    = r_free;
        n_res_num = r_res_num;
        n_res_was = r_res_was;
        n_res_bad = r_res_bad;
        o_ram     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op      = i_req.op;
                    n_num     = i_req.entry_number;
                    n_res_num = i_req.entry_number;
                    n_res_was = 1'b0;
                    n_res_bad = 1'b0;
                    if (i_req.op == OP_ALLOC) begin
                        n_lo0 = lo_m1[IDX_W-1:0];
                        n_hi0 = hi_m1[IDX_W-1:0];
                        n_word = lo_m1[IDX_W-1:BIT_W];
                        if (lo8 > hi8) begin
                            n_res_num = '0;
                            n_state   = S_DONE;
                        end else begin
                            n_state = S_READ;
                        end
                    end else if (bad_in) begin
                        n_res_bad = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        n_word  = idx[IDX_W-1:BIT_W];
                        n_bit   = idx[BIT_W-1:0];
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_ram.rd_en   = 1'b1;
                o_ram.rd_addr = r_word;
                n_state       = S_EVAL;
            end
            S_EVAL: begin
                o_ram.wr_addr = r_word;
                if (r_op == OP_ALLOC) begin
                    if (found) begin
                        o_ram.wr_en = 1'b1;
                        o_ram.wdata = i_ram_rdata | (WORD_W'(1) << found_pos);
                        n_res_num   = NUM_W'(found_idx) + NUM_W'(1);
                        if (r_free != '0) begin
                            n_free = r_free - NUM_W'(1);
                        end
                        n_state = S_DONE;
                    end else if (r_word == r_hi0[IDX_W-1:BIT_W]) begin
                        n_res_num = '0;
                        n_state   = S_DONE;
                    end else begin
                        n_word  = r_word + WADDR_W'(1);
                        n_state = S_READ;
                    end
                end else begin
                    n_res_was = was;
                    case (r_op)
                        OP_RELEASE: begin
                            if (was) begin
                                o_ram.wr_en = 1'b1;
                                o_ram.wdata = i_ram_rdata & ~(WORD_W'(1) << r_bit);
                                n_free      = r_free + NUM_W'(1);
                            end
                        end
                        OP_MARK: begin
                            if (!was) begin
                                o_ram.wr_en = 1'b1;
                                o_ram.wdata = i_ram_rdata | (WORD_W'(1) << r_bit);
                                if (r_free != '0) begin
                                    n_free = r_free - NUM_W'(1);
                                end
                            end
                        end
                        default: begin
                            n_free = r_free;
                        end
                    endcase
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= NUM_W'(NUM_ENTRIES);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_num     <= n_num;
        r_word    <= n_word;
        r_bit     <= n_bit;
        r_lo0     <= n_lo0;
        r_hi0     <= n_hi0;
        r_res_num <= n_res_num;
        r_res_was <= n_res_was;
        r_res_bad <= n_res_bad;
        if (load_out) begin
            r_out_num  <= r_res_num;
            r_out_was  <= r_res_was;
            r_out_free <= r_free;
            r_out_bad  <= r_res_bad;
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.result_number = r_out_num;
    assign o_rsp.was_in_use    = r_out_was;
    assign o_rsp.free_left     = r_out_free;
    assign o_rsp.bad_number    = r_out_bad;

    assign o_stat.free_total = r_free;
    assign o_stat.in_eval    = (r_state == S_EVAL);

endmodule

// File: rtl/core/bitmap_first_fit_allocator_top.sv
// Steps: release, mark-used and query with an entry number in range go through read, evaluate
// and done; allocate repeats read and evaluate for each map word scanned (1 to 4); a bad number
// or an empty window goes straight to done. Each map word costs one read and one evaluate step.
// Throughput: one request at a time; the next beat is taken the cycle after the result
// moves into the output register, even while that result still waits.
// Reset: map all free at once (per-row valid bits), free count 128, window 1..128.
module bitmap_first_fit_allocator_top import bfa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bfa_req_if.sink            i_req,
    bfa_rsp_if.source          o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg              cfg;
    t_ram_req          ram_req;
    logic [WORD_W-1:0] ram_rdata;
    t_stat             stat;

    bfa_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bfa_map_ram u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    bfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_ram       (ram_req),
        .i_ram_rdata (ram_rdata),
        .o_stat      (stat)
    );

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.free_total <= NUM_W'(NUM_ENTRIES))
        else $error("free count above pool size");

    a_write_in_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.wr_en |-> stat.in_eval)
        else $error("map write outside evaluate step");

    a_no_raw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.wr_en |=> !(ram_req.rd_en && ram_req.rd_addr == $past(ram_req.wr_addr)))
        else $error("map read right behind write to same row");

    a_bad_not_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.bad_number) |-> !o_rsp.was_in_use)
        else $error("bad number reported as in use");

endmodule

// File: sim/tb_bitmap_first_fit_allocator_top.sv
module tb_bitmap_first_fit_allocator_top import bfa_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES    = 7;
    localparam int PHASE_LEN = 220;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [NUM_W-1:0] result_number;
        logic             was_in_use;
        logic [NUM_W-1:0] free_left;
        logic             bad_number;
    } alloc_result_t;

    class allocation_tracker;
        bit              taken [1:NUM_ENTRIES];
        int unsigned     free_count;
        logic [CFG_W-1:0] win_first;
        logic [CFG_W-1:0] win_last;
        alloc_result_t   pending_results [$];
        int unsigned     mismatches;

        function new();
            foreach (taken[n]) taken[n] = 1'b0;
            free_count = NUM_ENTRIES;
            win_first  = FIRST_RESET;
            win_last   = LAST_RESET;
            mismatches = 0;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        function void take_request(t_op op, logic [NUM_W-1:0] num);
            alloc_result_t want;
            int lo;
            int hi;
            int n;
            bit found;
            want.result_number = num;
            want.was_in_use    = 1'b0;
            want.bad_number    = 1'b0;
            if (op == OP_ALLOC) begin
                lo = (win_first == 0) ? 1 : int'(win_first);
                hi = (win_last > NUM_ENTRIES) ? NUM_ENTRIES : int'(win_last);
                want.result_number = '0;
                found = 1'b0;
                for (n = lo; n <= hi && !found; n++) begin
                    if (!taken[n]) begin
                        taken[n] = 1'b1;
                        if (free_count > 0) free_count--;
                        want.result_number = NUM_W'(n);
                        found = 1'b1;
                    end
                end
            end else if (num == 0 || num > NUM_ENTRIES) begin
                want.bad_number = 1'b1;
            end else begin
                want.was_in_use = taken[num];
                if (op == OP_RELEASE && taken[num]) begin
                    taken[num] = 1'b0;
                    free_count++;
                end else if (op == OP_MARK && !taken[num]) begin
                    taken[num] = 1'b1;
                    if (free_count > 0) free_count--;
                end
            end
            want.free_left = NUM_W'(free_count);
            pending_results.push_back(want);
        endfunction

        task check_result(alloc_result_t got);
            alloc_result_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("result %0d with nothing outstanding", got.result_number));
                return;
            end
            want = pending_results.pop_front();
            if (got.result_number !== want.result_number)
                report($sformatf("result_number %0d, want %0d",
                                 got.result_number, want.result_number));
            if (got.was_in_use !== want.was_in_use)
                report($sformatf("was_in_use %0b, want %0b (result %0d)",
                                 got.was_in_use, want.was_in_use, want.result_number));
            if (got.free_left !== want.free_left)
                report($sformatf("free_left %0d, want %0d (result %0d)",
                                 got.free_left, want.free_left, want.result_number));
            if (got.bad_number !== want.bad_number)
                report($sformatf("bad_number %0b, want %0b (result %0d)",
                                 got.bad_number, want.bad_number, want.result_number));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bfa_req_if req_if ();
    bfa_rsp_if rsp_if ();

    allocation_tracker tracker;
    alloc_result_t     seen;
    bit                hold_off_request;
    int                burst_left;

    int unsigned phase_first [PHASES] = '{1, 0, 33, 100, 1, 90, 1};
    int unsigned phase_last  [PHASES] = '{128, 255, 96, 255, 16, 40, 128};
    int unsigned phase_alloc [PHASES] = '{80, 60, 50, 30, 70, 40, 15};

    bitmap_first_fit_allocator_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(4_000_000);
        $display("** bitmap_first_fit_allocator_top: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                tracker.take_request(req_if.op, req_if.entry_number);
            if (rsp_if.valid && rsp_if.ready) begin
                seen.result_number = rsp_if.result_number;
                seen.was_in_use    = rsp_if.was_in_use;
                seen.free_left     = rsp_if.free_left;
                seen.bad_number    = rsp_if.bad_number;
                tracker.check_result(seen);
            end
        end
    end

    // receiver: stall modes of random length, plus long hold-offs on request
    initial begin
        int mode;
        int mode_left;
        int cyc;
        mode      = 0;
        mode_left = 0;
        cyc       = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(3);
                mode_left = $urandom_range(64, 256);
            end
            mode_left--;
            case (mode)
                0: rsp_if.ready <= 1'b1;
                1: rsp_if.ready <= 1'($urandom_range(1));
                2: rsp_if.ready <= (cyc % 5) >= 2;
                default: rsp_if.ready <= ($urandom_range(5) == 0);
            endcase
        end
    end

    task apb_write(t_reg_idx idx, logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task offer(t_op op, logic [NUM_W-1:0] num);
        req_if.valid        <= 1'b1;
        req_if.op           <= op;
        req_if.entry_number <= num;
        do @(posedge i_clk); while (!req_if.ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
        end
    endtask

    task settle();
        req_if.valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task set_window(logic [CFG_W-1:0] first, logic [CFG_W-1:0] last);
        settle();
        apb_write(REG_FIRST, PDATA_W'(first));
        tracker.win_first = first;
        apb_write(REG_LAST, PDATA_W'(last));
        tracker.win_last = last;
    endtask

    initial begin
        int ph;
        int k;
        t_op op;
        logic [NUM_W-1:0] num;
        tracker          = new();
        hold_off_request = 1'b0;
        burst_left       = 0;
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.op           <= OP_ALLOC;
        req_if.entry_number <= '0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer(OP_QUERY, 8'd1);
        offer(OP_QUERY, 8'd128);
        offer(OP_QUERY, 8'd0);
        offer(OP_QUERY, 8'd255);
        offer(OP_RELEASE, 8'd129);
        offer(OP_ALLOC, 8'd0);
        offer(OP_ALLOC, 8'hFF);
        offer(OP_MARK, 8'd128);
        offer(OP_MARK, 8'd128);
        offer(OP_RELEASE, 8'd2);
        offer(OP_RELEASE, 8'd2);
        offer(OP_RELEASE, 8'd0);
        offer(OP_MARK, 8'd200);
        offer(OP_ALLOC, 8'd0);
        offer(OP_QUERY, 8'd1);
        offer(OP_MARK, 8'd3);
        set_window(8'd1, 8'd1);
        offer(OP_ALLOC, 8'd0);
        set_window(8'd0, 8'd255);
        offer(OP_ALLOC, 8'd0);
        set_window(8'd64, 8'd32);
        offer(OP_ALLOC, 8'd0);
        set_window(8'd128, 8'd128);
        offer(OP_ALLOC, 8'd0);
        offer(OP_RELEASE, 8'd128);
        offer(OP_ALLOC, 8'd0);
        set_window(8'd200, 8'd255);
        offer(OP_ALLOC, 8'd0);

        for (ph = 0; ph < PHASES; ph++) begin
            set_window(CFG_W'(phase_first[ph]), CFG_W'(phase_last[ph]));
            for (k = 0; k < PHASE_LEN; k++) begin
                if ((ph == 1 || ph == 4) && k == 100)
                    hold_off_request = 1'b1;
                if ($urandom_range(99) < phase_alloc[ph])
                    op = OP_ALLOC;
                else
                    op = t_op'(OP_W'($urandom_range(1, 3)));
                num = ($urandom_range(9) == 0) ? NUM_W'($urandom_range(255))
                                               : NUM_W'($urandom_range(1, NUM_ENTRIES));
                offer(op, num);
            end
        end

        settle();
        if (tracker.mismatches == 0)
            $display("** bitmap_first_fit_allocator_top: PASSED **");
        else
            $display("** bitmap_first_fit_allocator_top: FAILED **");
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/bfa_pkg.sv
rtl/core/bfa_req_if.sv
rtl/core/bfa_rsp_if.sv
rtl/core/bfa_map_ram.sv
rtl/core/bfa_cfg_regs.sv
rtl/core/bfa_ctrl.sv
rtl/core/bitmap_first_fit_allocator_top.sv
sim/tb_bitmap_first_fit_allocator_top.sv
